>>> src/bf7_pkg.sv
// Shared types and constants for the 7x7 box filter.
// Used by every module of the filter; depends on nothing.
package bf7_pkg;

    // Image geometry limits
    localparam int TAPS       = 7;
    localparam int LINES      = TAPS - 1;
    localparam int MARGIN     = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Field and register widths
    localparam int PIX_W   = 8;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int CSUM_W  = 11;
    localparam int TOTAL_W = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(MAX_HEIGHT);

    // Divide by 49: q = (t * 21400) >> 20 is exact for t < 16384
    localparam int DIV_MULT_W = 15;
    localparam int DIV_SHIFT  = 20;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 15'd21400;
    localparam int PROD_W = TOTAL_W + DIV_MULT_W;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             first_col;
        logic             produce;
        logic             last;
    } item_info_t;

endpackage

>>> src/bf7_position.sv
// Configuration registers and raster position counters of the box filter.
// Depends on bf7_pkg.
module bf7_position
    import bf7_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  frame_start,
    output item_info_t            info
);

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] col_pos_reg;
    logic [COL_W-1:0] col_pos_next;
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [COL_W-1:0] col_raw;
    logic [ROW_W-1:0] row_raw;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             col_wrap;
    logic             row_wrap;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Clamp the image size to the supported range
    always_comb
    begin
        if (width_reg < WID_W'(TAPS))
            w_eff = WID_W'(TAPS);
        else if (width_reg > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg < HGT_W'(TAPS))
            h_eff = HGT_W'(TAPS);
        else if (height_reg > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // Position of the current pixel, clipped to a shrunken image
    always_comb
    begin
        col_raw = frame_start ? '0 : col_pos_reg;
        row_raw = frame_start ? '0 : row_pos_reg;
        col = ({1'b0, col_raw} >= w_eff) ? COL_W'(w_eff - 1'b1) : col_raw;
        row = ({1'b0, row_raw} >= h_eff) ? ROW_W'(h_eff - 1'b1) : row_raw;

        col_wrap = ({1'b0, col} + WID_W'(1)) >= w_eff;
        row_wrap = ({1'b0, row} + HGT_W'(1)) >= h_eff;

        if (col_wrap)
        begin
            col_pos_next = '0;
            row_pos_next = row_wrap ? '0 : row + 1'b1;
        end
        else
        begin
            col_pos_next = col + 1'b1;
            row_pos_next = row;
        end

        info.col       = col;
        info.out_row   = row - ROW_W'(MARGIN);
        info.out_col   = col - COL_W'(MARGIN);
        info.first_col = (col == '0);
        info.produce   = (row >= ROW_W'(LINES)) && (col >= COL_W'(LINES));
        info.last      = ({1'b0, row} == h_eff - 1'b1) && ({1'b0, col} == w_eff - 1'b1);
    end

    // Advance the position on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (accept)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // Inside a row the column steps by one
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_start && ({1'b0, col_pos_reg} + WID_W'(1) < w_eff))
        |=> (col_pos_reg == $past(col_pos_reg) + 1'b1))
        else $error("column position did not advance by one");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> ({1'b0, col_pos_reg} < WID_W'(MAX_WIDTH)))
        else $error("column position beyond line store");

endmodule

>>> src/bf7_line_store.sv
// Six line stores packed into one 48-bit wide memory, one word per column,
// with write-to-read forwarding and the seven-pixel column sum.
// Depends on bf7_pkg.
module bf7_line_store
    import bf7_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_col,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_col,
    input  logic [PIX_W-1:0]  pixel,
    output logic [CSUM_W-1:0] colsum
);

    localparam int WORD_W = LINES * PIX_W;

    logic [WORD_W-1:0] mem [0:MAX_WIDTH-1];
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_sel_reg;
    logic [WORD_W-1:0] column;
    logic [WORD_W-1:0] wr_data;

    // Select forwarded word when the read hit a same-cycle write
    assign column  = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    // Shift the column down one line and put the new pixel on top
    assign wr_data = {column[WORD_W-PIX_W-1:0], pixel};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_col] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_col];
    end

    // Capture data written to the address being read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_sel_reg <= 1'b0;
        else if (rd_en)
            fwd_sel_reg <= wr_en && (wr_col == rd_col);
    end

    // Add this pixel and the six stored above it
    always_comb
    begin
        colsum = CSUM_W'(pixel);
        for (int k = 0; k < LINES; k++)
            colsum = colsum + CSUM_W'(column[k*PIX_W +: PIX_W]);
    end

    // Columns still holding lines not yet written in this frame carry no bound
    a_colsum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !$isunknown(colsum)) |-> (colsum <= CSUM_W'(TAPS * 255)))
        else $error("column sum out of range");

endmodule

>>> src/bf7_window.sv
// Sliding window of seven column sums and its running total.
// Depends on bf7_pkg.
module bf7_window
    import bf7_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               first_col,
    input  logic [CSUM_W-1:0]  colsum,
    output logic [TOTAL_W-1:0] total
);

    logic [CSUM_W-1:0]  win_reg [0:TAPS-1];
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] base;
    logic [CSUM_W-1:0]  oldest;
    logic [TOTAL_W-1:0] win_sum;

    // Clear the window at the start of each row
    assign base   = first_col ? '0 : total_reg;
    assign oldest = first_col ? '0 : win_reg[0];
    assign total  = base + TOTAL_W'(colsum) - TOTAL_W'(oldest);

    // Shift in the new column sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            for (int k = 0; k < TAPS; k++)
                win_reg[k] <= '0;
        end
        else if (en)
        begin
            total_reg <= total;
            for (int k = 0; k < TAPS - 1; k++)
                win_reg[k] <= first_col ? '0 : win_reg[k+1];
            win_reg[TAPS-1] <= colsum;
        end
    end

    always_comb
    begin
        win_sum = '0;
        for (int k = 0; k < TAPS; k++)
            win_sum = win_sum + TOTAL_W'(win_reg[k]);
    end

    // Running total always matches the window contents once they are known
    a_total_match: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(win_sum) |-> (total_reg == win_sum))
        else $error("window total out of step with window");

endmodule

>>> src/box_filter_7x7_unit.sv
// 7x7 box filter: each accepted pixel passes the registered stages line store read,
// column sum, window total and divide on its way to the result on m_axis.
// Throughput is one pixel per clock, set by the single read and single write
// port of the line store; backpressure stalls only the stages that are full.
// rst_n clears the pipeline, window and position counters and sets the size
// registers to 1024 x 4096; the line store is not cleared and needs no pass.
module box_filter_7x7_unit
    import bf7_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
    input  logic                  s_axis_tuser,   // [0] frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [7:0] smoothed, [19:8] out_row,
                                                  // [29:20] out_col, [31:30] zero
    output logic                  m_axis_tlast,   // frame_last
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               accept;
    item_info_t         pos_info;

    logic               s1_valid_reg;
    item_info_t         s1_info_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    logic               s2_valid_reg;
    item_info_t         s2_info_reg;
    logic [CSUM_W-1:0]  s2_colsum_reg;
    logic               s3_valid_reg;
    item_info_t         s3_info_reg;
    logic [TOTAL_W-1:0] s3_total_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_smoothed_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_last_reg;

    logic               ready2;
    logic               ready3;
    logic               ready_out;
    logic               adv1;
    logic               adv2;
    logic               adv3;
    logic [CSUM_W-1:0]  colsum;
    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  prod;

    // Stage handshakes: a stage takes new data when empty or draining
    assign ready_out     = !out_valid_reg || m_axis_tready;
    assign ready3        = !s3_valid_reg || ready_out;
    assign ready2        = !s2_valid_reg || ready3;
    assign s_axis_tready = !s1_valid_reg || ready2;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign adv1          = s1_valid_reg && ready2;
    assign adv2          = s2_valid_reg && ready3;
    assign adv3          = s3_valid_reg && ready_out;

    bf7_position u_position
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .frame_start (s_axis_tuser),
        .info        (pos_info)
    );

    bf7_line_store u_line_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_col (pos_info.col),
        .wr_en  (adv1),
        .wr_col (s1_info_reg.col),
        .pixel  (s1_pixel_reg),
        .colsum (colsum)
    );

    bf7_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv2),
        .first_col (s2_info_reg.first_col),
        .colsum    (s2_colsum_reg),
        .total     (total)
    );

    // Divide the window total by 49 through a reciprocal multiply
    assign prod = PROD_W'(s3_total_reg) * PROD_W'(DIV_MULT);

    // Valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (ready_out)
                out_valid_reg <= s3_valid_reg && s3_info_reg.produce;
        end
    end

    // Payload registers, loaded as each transaction moves on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg  <= pos_info;
            s1_pixel_reg <= s_axis_tdata;
        end
        if (adv1)
        begin
            s2_info_reg   <= s1_info_reg;
            s2_colsum_reg <= colsum;
        end
        if (adv2)
        begin
            s3_info_reg  <= s2_info_reg;
            s3_total_reg <= total;
        end
        if (adv3)
        begin
            out_smoothed_reg <= prod[DIV_SHIFT +: PIX_W];
            out_row_reg      <= s3_info_reg.out_row;
            out_col_reg      <= s3_info_reg.out_col;
            out_last_reg     <= s3_info_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_smoothed_reg};
    assign m_axis_tlast  = out_last_reg;

    // Input is held off only when the s1, s2 and s3 stages are all occupied
    a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("input stalled with a free stage");

    a_out_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_row_reg >= ROW_W'(MARGIN) && out_col_reg >= COL_W'(MARGIN)))
        else $error("result from a border position");

endmodule

>>> tb/sv/box_filter_7x7_unit_tb.sv
// Self-checking testbench for box_filter_7x7_unit: streams greyscale frames of many sizes
// through the filter and compares every smoothed pixel with a cycle-free software predictor.
// Depends on bf7_pkg and box_filter_7x7_unit only.
`timescale 1ns / 100ps

module box_filter_7x7_unit_tb;
    import bf7_pkg::*;

    localparam int AREA           = TAPS * TAPS;
    localparam int RANDOM_ITEMS   = 950;
    localparam int MAX_GAP        = 13;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        bit [PIX_W-1:0] smoothed;
        bit [ROW_W-1:0] out_row;
        bit [COL_W-1:0] out_col;
        bit             frame_last;
    } mean_pixel_t;

    typedef enum int {PIX_RANDOM, PIX_BRIGHT, PIX_DARK, PIX_FULL, PIX_ZERO} pixel_style_t;

    // Predictor of the filter plus the queue of smoothed pixels still owed by the block
    class smoothing_scoreboard;
        bit [PIX_W-1:0]   rows_above [LINES][MAX_WIDTH];
        bit [CSUM_W-1:0]  col_sums [TAPS];
        bit [TOTAL_W-1:0] total;
        int unsigned      row_pos;
        int unsigned      col_pos;
        bit [WID_W-1:0]   width_reg;
        bit [HGT_W-1:0]   height_reg;
        mean_pixel_t      expected_means[$];
        int               errors;
        int               checked;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
        endfunction

        static function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < TAPS)
                return TAPS;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = data[WID_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = data[HGT_W-1:0];
        endfunction

        // Advance the window by one accepted pixel; queue a smoothed pixel when it is interior
        function void take_pixel(bit [PIX_W-1:0] px, bit frame_start);
            int unsigned w;
            int unsigned h;
            int unsigned col;
            int unsigned row;
            int unsigned csum;
            int          k;
            mean_pixel_t m;
            w = clamp_size(width_reg, MAX_WIDTH);
            h = clamp_size(height_reg, MAX_HEIGHT);
            if (frame_start)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            col = (col_pos >= w) ? w - 1 : col_pos;
            row = (row_pos >= h) ? h - 1 : row_pos;
            if (col == 0)
            begin
                foreach (col_sums[i])
                    col_sums[i] = '0;
                total = '0;
            end
            // column sum over this pixel and the six rows above, then shift the column down
            csum = px;
            for (k = 0; k < LINES; k++)
                csum += rows_above[k][col];
            for (k = LINES - 1; k > 0; k--)
                rows_above[k][col] = rows_above[k-1][col];
            rows_above[0][col] = px;
            // slide the seven-column window
            total = total + CSUM_W'(csum) - col_sums[0];
            for (k = 0; k < TAPS - 1; k++)
                col_sums[k] = col_sums[k+1];
            col_sums[TAPS-1] = CSUM_W'(csum);
            if (row >= LINES && col >= LINES)
            begin
                m.smoothed   = PIX_W'(total / AREA);
                m.out_row    = ROW_W'(row - MARGIN);
                m.out_col    = COL_W'(col - MARGIN);
                m.frame_last = (row == h - 1) && (col == w - 1);
                expected_means.push_back(m);
            end
            if (col + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col_pos = col + 1;
                row_pos = row;
            end
        endfunction

        function void check_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest smoothed pixel owed
        function void check_output(bit [31:0] data, bit last);
            mean_pixel_t e;
            if (expected_means.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual data 0x%08h last %0d",
                         $time, data, last);
                return;
            end
            e = expected_means.pop_front();
            checked++;
            check_field("smoothed", e.smoothed, data[0 +: PIX_W]);
            check_field("out_row", e.out_row, data[PIX_W +: ROW_W]);
            check_field("out_col", e.out_col, data[PIX_W+ROW_W +: COL_W]);
            check_field("tdata padding", 0, data[31:PIX_W+ROW_W+COL_W]);
            check_field("frame_last", e.frame_last, last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    smoothing_scoreboard sb = new();
    int  pixels_sent;
    int  reg_writes;
    int  idle_cycles;
    bit  sender_steady;

    box_filter_7x7_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Observe every transaction; results are checked before the same edge's pixel is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_pixel(s_axis_tdata, s_axis_tuser);
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
                reg_writes++;
            end
            // watchdog: count edges with no transaction on any channel
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d results still owed", $time,
                         sb.expected_means.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles before each transaction
    initial
    begin
        int stall;
        bit steady;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Offer one pixel after a random gap and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic first);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= first;
        do @(posedge clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    // Stream a run of pixels; noisy runs scatter extra frame marks
    task automatic send_run(input int count, input bit marked, input pixel_style_t style,
                            input int eff_w, input bit noisy);
        int             i;
        logic [PIX_W-1:0] px;
        logic           first;
        for (i = 0; i < count; i++)
        begin
            if (i % eff_w == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            unique case (style)
                PIX_BRIGHT: px = PIX_W'($urandom_range(224, 255));
                PIX_DARK:   px = PIX_W'($urandom_range(0, 31));
                PIX_FULL:   px = '1;
                PIX_ZERO:   px = '0;
                default:    px = PIX_W'($urandom_range(0, 255));
            endcase
            first = (i == 0) ? marked : (noisy && $urandom_range(0, 19) == 0);
            send_pixel(px, first);
        end
    endtask

    // Hold the stream until every owed result is out and the pipeline has settled
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w_data,
                            input logic [CFG_DATA_W-1:0] h_data);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w_data);
        write_reg(REG_IMAGE_HEIGHT, h_data);
    endtask

    initial
    begin
        int               base;
        int               r;
        int               w_val;
        int               h_val;
        int               eff_w;
        int               eff_h;
        int               nframes;
        int               f;
        int               kind;
        int               frame_len;
        logic [CFG_DATA_W-1:0] w_data;
        pixel_style_t     style;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame, all white: the single output is the largest mean
        set_size(CFG_DATA_W'(7), CFG_DATA_W'(7));
        send_run(49, 1'b1, PIX_FULL, 7, 1'b0);

        // Stop partway into row 8 of a 10x10 frame, then shrink both sizes mid-frame:
        // the next pixel lands past the new last column and row, ends the frame and
        // wraps; the following unmarked frame of zeros starts from the wrap
        set_size(CFG_DATA_W'(10), CFG_DATA_W'(10));
        send_run(89, 1'b1, PIX_RANDOM, 10, 1'b0);
        set_size(CFG_DATA_W'(7), CFG_DATA_W'(8));
        send_run(57, 1'b0, PIX_ZERO, 7, 1'b0);

        // Width register all ones clamps to the widest row; a short start of the first row
        set_size('1, CFG_DATA_W'(7));
        send_run(64, 1'b1, PIX_RANDOM, MAX_WIDTH, 1'b0);

        // Width below the minimum and height all ones: a partial frame of the tallest image
        set_size(CFG_DATA_W'(3), '1);
        send_run(7 * 12, 1'b1, PIX_BRIGHT, 7, 1'b0);

        // Random phases: new sizes, then a few frames of mostly well-formed shape
        base = pixels_sent;
        while (pixels_sent - base < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            w_val = (r < 14) ? $urandom_range(7, 16) :
                    (r < 17) ? $urandom_range(17, 40) : $urandom_range(0, 6);
            r = $urandom_range(0, 19);
            h_val = (r < 14) ? $urandom_range(7, 11) :
                    (r < 16) ? $urandom_range(12, 20) :
                    (r < 18) ? $urandom_range(0, 6) : $urandom_range(MAX_HEIGHT + 1, 8191);
            w_data = CFG_DATA_W'(w_val);
            w_data[CFG_DATA_W-1:WID_W] = (CFG_DATA_W-WID_W)'($urandom_range(0, 3));
            set_size(w_data, CFG_DATA_W'(h_val));
            eff_w = smoothing_scoreboard::clamp_size(w_val, MAX_WIDTH);
            eff_h = smoothing_scoreboard::clamp_size(h_val, MAX_HEIGHT);

            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
            begin
                kind  = $urandom_range(0, 9);
                style = pixel_style_t'($urandom_range(0, 2));
                frame_len = eff_w * ((eff_h > 20) ? $urandom_range(7, 12) : eff_h);
                // the first frame after a size change always carries its mark
                if (kind < 7 || f == 0)
                    send_run(frame_len, 1'b1, style, eff_w, 1'b0);
                else if (kind == 7)
                    send_run($urandom_range(1, frame_len - 1), 1'b1, style, eff_w, 1'b0);
                else if (kind == 8)
                    send_run(frame_len, 1'b0, style, eff_w, 1'b0);
                else
                    send_run($urandom_range(eff_w, frame_len), 1'b1, PIX_RANDOM, eff_w, 1'b1);
            end
        end

        wait_drained();
        if (sb.expected_means.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_means.size());
        end
        $display("Streamed %0d pixels across %0d register writes and checked %0d smoothed pixels.",
                 pixels_sent, reg_writes, sb.checked);
        $display("Sizes spanned 7x7 up to 1024 wide and 4096 tall, with marks, wraps and shrinks.");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
src/bf7_pkg.sv
src/bf7_position.sv
src/bf7_line_store.sv
src/bf7_window.sv
src/box_filter_7x7_unit.sv
tb/sv/box_filter_7x7_unit_tb.sv
